### src/bbf_pkg.sv
// -----------------------------------------------------------------------------
// bbf_pkg
// Shared widths, register indexes, multiplier operand codes and payload types
// for the Butterworth biquad filter.
// -----------------------------------------------------------------------------
package bbf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 18;
   localparam int COEF_FRAC  = 14;
   localparam int DELAY_W    = 40;
   localparam int DELAY_FRAC = 8;
   localparam int OUT_FRAC   = COEF_FRAC + DELAY_FRAC;
   localparam int ACC_W      = 60;
   localparam int LO_W       = DELAY_W / 2;
   localparam int HI_W       = DELAY_W - LO_W;
   localparam int PLO_W      = COEF_W + LO_W + 1;
   localparam int PHI_W      = COEF_W + HI_W;
   localparam int NUM_COEF   = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int OUT_MAX    = 32767;

   // coefficient register indexes
   localparam logic [CSR_IDX_W-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A2 = 3'd4;

   // multiplier operand pairs
   localparam logic [2:0] MUL_A1W1 = 3'd0;
   localparam logic [2:0] MUL_A2W2 = 3'd1;
   localparam logic [2:0] MUL_B1W1 = 3'd2;
   localparam logic [2:0] MUL_B2W2 = 3'd3;
   localparam logic [2:0] MUL_B0WN = 3'd4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       block_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       block_end_out;
   } rsp_type;

   typedef struct packed {
      logic       load;      // latch input sample, seed feedback sum
      logic [2:0] mul_sel;   // operand pair for the multiplier
      logic       fb_sub;    // feedback sum -= product
      logic       w_load;    // capture saturated new intermediate value
      logic       ff_init;   // feed-forward sum = product
      logic       ff_add;    // feed-forward sum += product
      logic       out_load;  // load result register, shift delays
   } cmd_type;

   typedef struct packed {
      logic out_hold;        // result register full and not taken this cycle
   } sts_type;

endpackage

### src/butterworth_biquad_filter.sv
// -----------------------------------------------------------------------------
// butterworth_biquad_filter
// Second-order IIR biquad, direct form II, 16-bit PCM in and out.
// -----------------------------------------------------------------------------
// Each accepted sample x gives exactly one output sample. The filter forms
// w = x - a1*w1 - a2*w2 (Q.8, truncated toward zero, saturated to 40 bits)
// and y = b0*w + b1*w1 + b2*w2 (truncated toward zero, clamped to +/-32767),
// then shifts the delays. Coefficients are signed Q3.14 in csr registers
// 0..4 (b0, b1, b2, a1, a2), reset to zero; writes to other indexes are
// dropped, and writes belong in idle time only. A new sample is taken only
// when the last is done: the five 18x40 coefficient products go through
// a single multiplier (18x21 and 18x20 partials per cycle, registered), and the
// b0*w product has to wait for the saturated w from the feedback sum. The
// output register lets a finished sample sit while rsp_stall is high; the
// sequencer only pauses at its final step if the previous sample was not yet
// taken. block_end is carried along unchanged as block_end_out.
// -----------------------------------------------------------------------------
module butterworth_biquad_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bbf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bbf_pkg::COEF_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bbf_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bbf_pkg::rsp_type              rsp_data
);

   bbf_pkg::cmd_type cmd;
   bbf_pkg::sts_type sts;

   // sequencer: one step per multiplier use, then the final sum and output steps
   bbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic, state and result register
   bbf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a transfer in always starts a busy stretch
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again without processing");

endmodule

### src/bbf_ctrl.sv
// -----------------------------------------------------------------------------
// bbf_ctrl
// Sequencer for the biquad: steps the shared multiplier through the five
// coefficient products of one sample and issues datapath commands.
// -----------------------------------------------------------------------------
module bbf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bbf_pkg::sts_type sts,
   output bbf_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_A1   = 3'd1;
   localparam logic [2:0] ST_A2   = 3'd2;
   localparam logic [2:0] ST_B1   = 3'd3;
   localparam logic [2:0] ST_WN   = 3'd4;
   localparam logic [2:0] ST_B0   = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = bbf_pkg::MUL_A1W1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_A1;
            end
         end
         ST_A1: begin
            cmd.mul_sel = bbf_pkg::MUL_A1W1;
            state_in    = ST_A2;
         end
         ST_A2: begin
            cmd.mul_sel = bbf_pkg::MUL_A2W2;
            cmd.fb_sub  = 1'b1;
            state_in    = ST_B1;
         end
         ST_B1: begin
            cmd.mul_sel = bbf_pkg::MUL_B1W1;
            cmd.fb_sub  = 1'b1;
            state_in    = ST_WN;
         end
         ST_WN: begin
            cmd.mul_sel = bbf_pkg::MUL_B2W2;
            cmd.w_load  = 1'b1;
            cmd.ff_init = 1'b1;
            state_in    = ST_B0;
         end
         ST_B0: begin
            cmd.mul_sel = bbf_pkg::MUL_B0WN;
            cmd.ff_add  = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            cmd.ff_add = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!sts.out_hold) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/bbf_datapath.sv
// -----------------------------------------------------------------------------
// bbf_datapath
// Coefficient registers, delay line, split 18x40 multiplier, feedback and
// feed-forward sums, rounding/saturation and the result register.
// -----------------------------------------------------------------------------
module bbf_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [bbf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bbf_pkg::COEF_W-1:0]           csr_wdata,
   input  bbf_pkg::req_type                     req_data,
   input  bbf_pkg::cmd_type                     cmd,
   output bbf_pkg::sts_type                     sts,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bbf_pkg::rsp_type                     rsp_data
);

   localparam int ACC_W   = bbf_pkg::ACC_W;
   localparam int DELAY_W = bbf_pkg::DELAY_W;
   localparam int COEF_W  = bbf_pkg::COEF_W;
   localparam int LO_W    = bbf_pkg::LO_W;
   localparam int HI_W    = bbf_pkg::HI_W;
   localparam int PLO_W   = bbf_pkg::PLO_W;
   localparam int PHI_W   = bbf_pkg::PHI_W;
   localparam int WQ_W    = ACC_W - bbf_pkg::COEF_FRAC;
   localparam int YQ_W    = ACC_W - bbf_pkg::OUT_FRAC;

   localparam logic signed [WQ_W-1:0] W_MAX = WQ_W'((64'sd1 <<< (DELAY_W - 1)) - 64'sd1);
   localparam logic signed [WQ_W-1:0] W_MIN = -WQ_W'(64'sd1 <<< (DELAY_W - 1));
   localparam logic signed [YQ_W-1:0] Y_MAX = YQ_W'(bbf_pkg::OUT_MAX);
   localparam logic signed [YQ_W-1:0] Y_MIN = -YQ_W'(bbf_pkg::OUT_MAX);

   // coefficients
   logic signed [COEF_W-1:0] coef_ff [bbf_pkg::NUM_COEF];
   logic signed [COEF_W-1:0] coef_in [bbf_pkg::NUM_COEF];

   always_comb begin
      for (int i = 0; i < bbf_pkg::NUM_COEF; i++) begin
         coef_in[i] = coef_ff[i];
         if (csr_we && (csr_index == bbf_pkg::CSR_IDX_W'(i))) begin
            coef_in[i] = csr_wdata;
         end
      end
   end

   // delay line and new intermediate value
   logic signed [DELAY_W-1:0] w1_ff, w1_in, w2_ff, w2_in, wn_ff, wn_in;
   logic                      be_ff, be_in;

   // multiplier operands
   logic signed [COEF_W-1:0]  mul_coef;
   logic signed [DELAY_W-1:0] mul_data;

   always_comb begin
      unique case (cmd.mul_sel)
         bbf_pkg::MUL_A1W1: begin
            mul_coef = coef_ff[bbf_pkg::REG_A1];
            mul_data = w1_ff;
         end
         bbf_pkg::MUL_A2W2: begin
            mul_coef = coef_ff[bbf_pkg::REG_A2];
            mul_data = w2_ff;
         end
         bbf_pkg::MUL_B1W1: begin
            mul_coef = coef_ff[bbf_pkg::REG_B1];
            mul_data = w1_ff;
         end
         bbf_pkg::MUL_B2W2: begin
            mul_coef = coef_ff[bbf_pkg::REG_B2];
            mul_data = w2_ff;
         end
         bbf_pkg::MUL_B0WN: begin
            mul_coef = coef_ff[bbf_pkg::REG_B0];
            mul_data = wn_ff;
         end
         default: begin
            mul_coef = '0;
            mul_data = '0;
         end
      endcase
   end

   // 18x40 product as registered 18x21 and 18x20 partials
   logic signed [PLO_W-1:0] plo_ff, plo_in;
   logic signed [PHI_W-1:0] phi_ff, phi_in;
   logic signed [ACC_W-1:0] prod_full;

   assign plo_in    = mul_coef * $signed({1'b0, mul_data[LO_W-1:0]});
   assign phi_in    = mul_coef * $signed(mul_data[DELAY_W-1:LO_W]);
   assign prod_full = (ACC_W'(phi_ff) <<< LO_W) + ACC_W'(plo_ff);

   // sums
   logic signed [ACC_W-1:0] fb_ff, fb_in, ff_ff, ff_in;

   always_comb begin
      fb_in = fb_ff;
      if (cmd.load) begin
         fb_in = ACC_W'(req_data.sample_in) <<< bbf_pkg::OUT_FRAC;
      end else if (cmd.fb_sub) begin
         fb_in = fb_ff - prod_full;
      end
      ff_in = ff_ff;
      if (cmd.ff_init) begin
         ff_in = prod_full;
      end else if (cmd.ff_add) begin
         ff_in = ff_ff + prod_full;
      end
   end

   // w: truncate toward zero to Q.8, saturate to 40 bits
   logic signed [ACC_W-1:0] fb_bias;
   logic signed [WQ_W-1:0]  w_q;

   assign fb_bias = fb_ff + (fb_ff[ACC_W-1] ?
                    ACC_W'((64'sd1 <<< bbf_pkg::COEF_FRAC) - 64'sd1) : ACC_W'(0));
   assign w_q     = WQ_W'(fb_bias >>> bbf_pkg::COEF_FRAC);

   always_comb begin
      wn_in = wn_ff;
      if (cmd.w_load) begin
         priority if (w_q > W_MAX) begin
            wn_in = DELAY_W'(W_MAX);
         end else if (w_q < W_MIN) begin
            wn_in = DELAY_W'(W_MIN);
         end else begin
            wn_in = DELAY_W'(w_q);
         end
      end
   end

   // y: truncate toward zero to integer, clamp
   logic signed [ACC_W-1:0]          ff_bias;
   logic signed [YQ_W-1:0]           y_q;
   logic signed [bbf_pkg::SAMPLE_W-1:0] y_sat;

   assign ff_bias = ff_ff + (ff_ff[ACC_W-1] ?
                    ACC_W'((64'sd1 <<< bbf_pkg::OUT_FRAC) - 64'sd1) : ACC_W'(0));
   assign y_q     = YQ_W'(ff_bias >>> bbf_pkg::OUT_FRAC);

   always_comb begin
      priority if (y_q > Y_MAX) begin
         y_sat = bbf_pkg::SAMPLE_W'(Y_MAX);
      end else if (y_q < Y_MIN) begin
         y_sat = bbf_pkg::SAMPLE_W'(Y_MIN);
      end else begin
         y_sat = bbf_pkg::SAMPLE_W'(y_q);
      end
   end

   // delays, block marker
   always_comb begin
      w1_in = w1_ff;
      w2_in = w2_ff;
      if (cmd.out_load) begin
         w1_in = wn_ff;
         w2_in = w1_ff;
      end
      be_in = cmd.load ? req_data.block_end : be_ff;
   end

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   bbf_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.sample_out    = y_sat;
         rsp_data_in.block_end_out = be_ff;
      end
   end

   assign sts.out_hold = rsp_valid_ff && rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bbf_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
         w1_ff        <= '0;
         w2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_ff      <= coef_in;
         w1_ff        <= w1_in;
         w2_ff        <= w2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wn_ff       <= wn_in;
      be_ff       <= be_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      fb_ff       <= fb_in;
      ff_ff       <= ff_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !sts.out_hold)
      else $error("result register loaded while a result is pending");

   // delay line moves only when a result is produced
   a_delay_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.out_load |=> ($stable(w1_ff) && $stable(w2_ff)))
      else $error("delay line changed without a result");

   // clamp keeps -32768 off the output
   a_no_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.sample_out != -16'sd32768))
      else $error("output sample outside clamp range");

endmodule
